// ===== rtl/core/lsm_pkg.sv =====
// Shared constants, types and helpers for the line substring matcher.
`default_nettype none
package lsm_pkg;

  localparam int MAX_QUERY   = 32;
  localparam int LINE_BUFFER = 200;
  localparam int QREG_BYTES  = 32;
  localparam int QREG_WORDS  = 4;
  localparam int CFG_W       = 64;
  localparam int CFG_IDX_W   = 3;
  localparam int QLEN_REG_W  = 6;
  localparam int LEN_W       = 8;
  localparam int IDX_W       = 32;
  localparam int IN_DATA_W   = 8;
  localparam int OUT_DATA_W  = 48;

  // Usable query length is bounded by both the window and the register bytes.
  localparam int QLIM     = (MAX_QUERY < QREG_BYTES) ? MAX_QUERY : QREG_BYTES;
  localparam int EL_W     = $clog2(QLIM + 1);
  localparam int QB_IDX_W = $clog2(QREG_BYTES);
  localparam int FILL_W   = $clog2(LINE_BUFFER);
  localparam int CMP_W    = (FILL_W > EL_W) ? FILL_W : EL_W;

  localparam logic [FILL_W-1:0] FILL_LIMIT = FILL_W'(LINE_BUFFER - 1);

  localparam logic [7:0] NEWLINE_CHR = 8'h0A;
  localparam logic [7:0] NUL_CHR     = 8'h00;
  localparam logic [7:0] UPPER_A     = 8'h41;
  localparam logic [7:0] UPPER_Z     = 8'h5A;
  localparam logic [7:0] CASE_OFS    = 8'h20;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_QUERY_LO     = 3'd0,
    REG_QUERY_MID_LO = 3'd1,
    REG_QUERY_MID_HI = 3'd2,
    REG_QUERY_HI     = 3'd3,
    REG_QUERY_LEN    = 3'd4,
    REG_FOLD_CASE    = 3'd5
  } cfg_reg_t;

  typedef logic [7:0] byte_t;

  // Query right-aligned against the window: pattern[k] meets window entry k.
  typedef struct packed {
    logic [QLIM-1:0]   mask;
    byte_t [QLIM-1:0]  pattern;
    logic [EL_W-1:0]   eff_len;
    logic              fold;
  } qprep_t;

  typedef struct packed {
    logic              valid;
    logic              matched;
    logic [IDX_W-1:0]  index;
    logic [LEN_W-1:0]  length;
    logic              cut;
  } chunk_res_t;

  function automatic byte_t fold_byte(input byte_t b, input logic en);
    byte_t r;
    r = b;
    if (en && (b >= UPPER_A) && (b <= UPPER_Z)) begin
      r = b + CASE_OFS;
    end
    return r;
  endfunction

endpackage
`default_nettype wire

// ===== rtl/core/lsm_qprep.sv =====
// Query preparation: effective length and right-aligned, folded pattern.
`default_nettype none
module lsm_qprep (
  input  wire logic [lsm_pkg::QREG_WORDS-1:0][lsm_pkg::CFG_W-1:0] q_words,
  input  wire logic [lsm_pkg::QLEN_REG_W-1:0]                     q_len,
  input  wire logic                                               fold_en,
  output lsm_pkg::qprep_t                                         prep
);

  lsm_pkg::byte_t [lsm_pkg::QREG_BYTES-1:0] qb;
  logic [lsm_pkg::EL_W-1:0]                 clamped;
  logic [lsm_pkg::EL_W-1:0]                 eff;
  logic [lsm_pkg::QB_IDX_W-1:0]             sel;

  assign qb = q_words;

  always_comb begin
    if (int'(q_len) > lsm_pkg::QLIM) begin
      clamped = lsm_pkg::EL_W'(lsm_pkg::QLIM);
    end else begin
      clamped = lsm_pkg::EL_W'(q_len);
    end

    // cut at the first zero query byte; lowest index wins
    eff = clamped;
    for (int i = lsm_pkg::QLIM - 1; i >= 0; i--) begin
      if ((i < int'(clamped)) && (qb[i] == lsm_pkg::NUL_CHR)) begin
        eff = lsm_pkg::EL_W'(i);
      end
    end

    sel          = '0;
    prep.eff_len = eff;
    prep.fold    = fold_en;
    for (int k = 0; k < lsm_pkg::QLIM; k++) begin
      prep.mask[k]    = (k < int'(eff));
      sel             = lsm_pkg::QB_IDX_W'(int'(eff) - 1 - k);
      prep.pattern[k] = prep.mask[k] ? lsm_pkg::fold_byte(qb[sel], fold_en) : '0;
    end
  end

endmodule
`default_nettype wire

// ===== rtl/core/lsm_scan.sv =====
// Chunk scanner: byte window, fill count, match flag and chunk counter.
`default_nettype none
module lsm_scan (
  input  wire logic                   clk,
  input  wire logic                   rst_n,
  input  wire logic                   step,
  input  wire lsm_pkg::byte_t         text_byte,
  input  wire logic                   end_of_text,
  input  wire lsm_pkg::qprep_t        prep,
  output lsm_pkg::chunk_res_t         res
);

  lsm_pkg::byte_t [lsm_pkg::MAX_QUERY-1:0] window_r, window_nxt, shifted;
  logic [lsm_pkg::FILL_W-1:0]              fill_r, fill_nxt, fill_inc, fill_fin;
  logic                                    found_r, found_nxt, found_fin;
  logic                                    zero_r, zero_nxt, zero_now;
  logic [lsm_pkg::IDX_W-1:0]               count_r, count_nxt;
  logic                                    all_eq, hit, finish, cut;

  always_comb begin
    shifted[0] = text_byte;
    for (int i = 1; i < lsm_pkg::MAX_QUERY; i++) begin
      shifted[i] = window_r[i-1];
    end

    zero_now = zero_r | (text_byte == lsm_pkg::NUL_CHR);
    fill_inc = fill_r + 1'b1;

    all_eq = 1'b1;
    for (int k = 0; k < lsm_pkg::QLIM; k++) begin
      if (prep.mask[k] &&
          (lsm_pkg::fold_byte(shifted[k], prep.fold) != prep.pattern[k])) begin
        all_eq = 1'b0;
      end
    end
    hit = !zero_now && (prep.eff_len != '0) && all_eq &&
          (lsm_pkg::CMP_W'(fill_inc) >= lsm_pkg::CMP_W'(prep.eff_len));

    window_nxt = window_r;
    fill_nxt   = fill_r;
    found_nxt  = found_r;
    zero_nxt   = zero_r;
    count_nxt  = count_r;
    finish     = 1'b0;
    cut        = 1'b0;
    found_fin  = found_r;
    fill_fin   = fill_r;

    if (end_of_text) begin
      finish = (fill_r != '0);
    end else if (text_byte == lsm_pkg::NEWLINE_CHR) begin
      finish = 1'b1;
    end else begin
      // bytes from a zero byte on stay out of the window
      if (!zero_now) begin
        window_nxt = shifted;
      end
      fill_nxt  = fill_inc;
      zero_nxt  = zero_now;
      found_nxt = found_r | hit;
      if (fill_inc >= lsm_pkg::FILL_LIMIT) begin
        finish    = 1'b1;
        cut       = 1'b1;
        found_fin = found_nxt;
        fill_fin  = fill_inc;
      end
    end

    res.valid   = finish;
    res.matched = found_fin | (prep.eff_len == '0);
    res.index   = count_r;
    res.length  = lsm_pkg::LEN_W'(fill_fin);
    res.cut     = cut;

    if (finish) begin
      fill_nxt  = '0;
      found_nxt = 1'b0;
      zero_nxt  = 1'b0;
      if (count_r != '1) begin
        count_nxt = count_r + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fill_r  <= '0;
      found_r <= 1'b0;
      zero_r  <= 1'b0;
      count_r <= '0;
    end else if (step) begin
      fill_r  <= fill_nxt;
      found_r <= found_nxt;
      zero_r  <= zero_nxt;
      count_r <= count_nxt;
    end
  end

  // window entries beyond the fill count never decide a match
  always_ff @(posedge clk) begin
    if (step) begin
      window_r <= window_nxt;
    end
  end

endmodule
`default_nettype wire

// ===== rtl/core/line_substring_matcher.sv =====
// Top level of the fixed-string line matcher: config, input and result registers.
//
//  port group | dir | carries
//  in_*       | in  | one text byte per word; tlast marks end of text
//  out_*      | out | one word per finished chunk: match, index, length; tuser cut flag
//  cfg_*      | in  | register writes, index 0..5, no read-back
//
// Takes one byte per cycle unless stalled; each result is registered in out_r.
// The rate is set by the combinational window compare between the input and result registers.
// Reset is synchronous (rst_n low); no clearing pass is needed after it.
// With out_tready low the result holds and one more byte parks in the input register,
// then in_tready drops.
`default_nettype none
module line_substring_matcher (
  input  wire logic                           clk,
  input  wire logic                           rst_n,
  input  wire logic                           in_tvalid,
  output logic                                in_tready,
  input  wire logic [lsm_pkg::IN_DATA_W-1:0]  in_tdata,   // [7:0] text_byte
  input  wire logic                           in_tlast,   // end_of_text
  output logic                                out_tvalid,
  input  wire logic                           out_tready,
  output logic [lsm_pkg::OUT_DATA_W-1:0]      out_tdata,  // [0] line_matched,
                                                          // [32:1] line_index,
                                                          // [40:33] line_length, rest 0
  output logic                                out_tuser,  // [0] cut_short
  input  wire logic                           cfg_wr_en,
  input  wire logic [lsm_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [lsm_pkg::CFG_W-1:0]      cfg_wdata
);

  logic [lsm_pkg::QREG_WORDS-1:0][lsm_pkg::CFG_W-1:0] q_words_r;
  logic [lsm_pkg::QLEN_REG_W-1:0]                     q_len_r;
  logic                                               fold_r;

  logic                  in_v_r;
  lsm_pkg::byte_t        in_byte_r;
  logic                  in_eot_r;
  logic                  advance;

  lsm_pkg::qprep_t       prep;
  lsm_pkg::chunk_res_t   res;
  lsm_pkg::chunk_res_t   out_r;

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      q_words_r <= '0;
      q_len_r   <= '0;
      fold_r    <= 1'b0;
    end else if (cfg_wr_en) begin
      case (cfg_index)
        lsm_pkg::REG_QUERY_LO:     q_words_r[0] <= cfg_wdata;
        lsm_pkg::REG_QUERY_MID_LO: q_words_r[1] <= cfg_wdata;
        lsm_pkg::REG_QUERY_MID_HI: q_words_r[2] <= cfg_wdata;
        lsm_pkg::REG_QUERY_HI:     q_words_r[3] <= cfg_wdata;
        lsm_pkg::REG_QUERY_LEN:    q_len_r      <= cfg_wdata[lsm_pkg::QLEN_REG_W-1:0];
        lsm_pkg::REG_FOLD_CASE:    fold_r       <= cfg_wdata[0];
        default: ;
      endcase
    end
  end

  // advance the held word whenever the result slot is free or draining
  assign advance   = in_v_r && (!out_r.valid || out_tready);
  assign in_tready = !in_v_r || advance;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_v_r <= 1'b0;
    end else if (in_tready) begin
      in_v_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tready && in_tvalid) begin
      in_byte_r <= in_tdata[7:0];
      in_eot_r  <= in_tlast;
    end
  end

  lsm_qprep u_qprep (
    .q_words (q_words_r),
    .q_len   (q_len_r),
    .fold_en (fold_r),
    .prep    (prep)
  );

  lsm_scan u_scan (
    .clk         (clk),
    .rst_n       (rst_n),
    .step        (advance),
    .text_byte   (in_byte_r),
    .end_of_text (in_eot_r),
    .prep        (prep),
    .res         (res)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_r.valid <= 1'b0;
    end else if (advance && res.valid) begin
      out_r <= res;
    end else if (out_tready) begin
      out_r.valid <= 1'b0;
    end
  end

  assign out_tvalid = out_r.valid;
  assign out_tdata  = {7'b0, out_r.length, out_r.index, out_r.matched};
  assign out_tuser  = out_r.cut;

endmodule
`default_nettype wire
